[hw/rtl/sdt_pkg.sv]
// Shared types for the service description section walker.
// Record kind codes and the result record struct; no dependencies.
package sdt_pkg;

    typedef enum logic [1:0] {
        KIND_SERVICE = 2'd0,
        KIND_END     = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    localparam logic [12:0] LOOP_START = 13'd11;
    localparam logic [12:0] POS_MAX    = 13'h1FFF;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] network_id;
        logic [15:0] program_number;
        logic        eit_schedule;
        logic        eit_present_following;
        logic [2:0]  running_state;
        logic        scrambled;
        logic [11:0] descriptor_bytes;
        logic [9:0]  service_index;
        logic        section_done;
    } t_rec;

endpackage

[hw/rtl/sdt_walk.sv]
// Section walk state and per-byte decode: position, service loop pointer,
// network id capture, header shift register. Uses sdt_pkg.
module sdt_walk import sdt_pkg::*; #(
    parameter int MAX_SECTION_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_data_byte,
    input  logic [12:0] i_section_length,
    input  logic        i_first_byte,
    output logic        o_hit,
    output t_rec        o_rec
);

    localparam logic [12:0] LenMax = 13'(MAX_SECTION_BYTES);

    logic [12:0] r_pos, n_pos;
    logic [12:0] r_svc_start, n_svc_start;
    logic [15:0] r_nid, n_nid;
    logic [31:0] r_hdr, n_hdr;
    logic [9:0]  r_cnt, n_cnt;
    logic        r_err, n_err;

    logic [12:0] cur_pos, cur_s, len_c;
    logic [15:0] cur_nid;
    logic [31:0] cur_hdr;
    logic [9:0]  cur_cnt;
    logic        cur_err;
    logic [13:0] s4, nxt, pos_x;
    logic [11:0] dll;

    always_comb begin
        len_c   = (i_section_length > LenMax) ? LenMax : i_section_length;
        cur_pos = i_first_byte ? '0 : r_pos;
        cur_s   = i_first_byte ? LOOP_START : r_svc_start;
        cur_nid = i_first_byte ? '0 : r_nid;
        cur_hdr = i_first_byte ? '0 : r_hdr;
        cur_cnt = i_first_byte ? '0 : r_cnt;
        cur_err = i_first_byte ? 1'b0 : r_err;

        n_pos       = (cur_pos != POS_MAX) ? cur_pos + 13'd1 : cur_pos;
        n_svc_start = cur_s;
        n_nid       = cur_nid;
        n_hdr       = cur_hdr;
        n_cnt       = cur_cnt;
        n_err       = cur_err;

        s4    = {1'b0, cur_s} + 14'd4;
        pos_x = {1'b0, cur_pos};
        dll   = {cur_hdr[3:0], i_data_byte};
        nxt   = {1'b0, cur_s} + 14'd5 + {2'b00, dll};

        o_hit = 1'b0;
        o_rec = '0;
        o_rec.kind = KIND_SERVICE;

        if (!cur_err && cur_pos < len_c) begin
            if (cur_pos == 13'd8) begin
                n_nid = {i_data_byte, cur_nid[7:0]};
            end else if (cur_pos == 13'd9) begin
                n_nid = {cur_nid[15:8], i_data_byte};
            end

            if (s4 < {1'b0, len_c} && cur_pos >= cur_s && pos_x <= s4) begin
                if (pos_x < s4) begin
                    n_hdr = {cur_hdr[23:0], i_data_byte};
                end else begin
                    o_hit               = 1'b1;
                    o_rec.network_id    = n_nid;
                    o_rec.service_index = cur_cnt;
                    n_hdr               = '0;
                    if (nxt > {1'b0, len_c - 13'd4}) begin
                        n_err              = 1'b1;
                        o_rec.kind         = KIND_ERROR;
                        o_rec.section_done = 1'b1;
                    end else begin
                        o_rec.program_number        = cur_hdr[31:16];
                        o_rec.eit_schedule          = cur_hdr[9];
                        o_rec.eit_present_following = cur_hdr[8];
                        o_rec.running_state         = cur_hdr[7:5];
                        o_rec.scrambled             = cur_hdr[4];
                        o_rec.descriptor_bytes      = dll;
                        n_cnt                       = cur_cnt + 10'd1;
                        n_svc_start                 = nxt[12:0];
                    end
                end
            end

            if (!o_hit && cur_pos == len_c - 13'd1) begin
                o_hit               = 1'b1;
                o_rec.kind          = KIND_END;
                o_rec.network_id    = n_nid;
                o_rec.service_index = cur_cnt;
                o_rec.section_done  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_svc_start <= LOOP_START;
            r_nid       <= '0;
            r_hdr       <= '0;
            r_cnt       <= '0;
            r_err       <= 1'b0;
        end else if (i_fire) begin
            r_pos       <= n_pos;
            r_svc_start <= n_svc_start;
            r_nid       <= n_nid;
            r_hdr       <= n_hdr;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
        end
    end

endmodule

[hw/rtl/sdt_service_loop_parser.sv]
// Channel  Dir  Handshake                 Payload
// in       in   i_in_valid / o_in_stall   data_byte, section_length, first_byte
// out      out  o_out_valid / i_out_stall service record, end or error record
// One item per cycle unless o_in_stall holds: input register, then decode
// into the result register. A result follows its item through the input
// register and then the result register; at most one result per item.
// Synchronous active-low reset clears the walk state (position 0, loop at 11).
// o_in_stall rises only when the input register is full and the result
// register is full and stalled.
// Top level of the service loop parser; uses sdt_pkg and sdt_walk.
module sdt_service_loop_parser import sdt_pkg::*; #(
    parameter int MAX_SECTION_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [12:0] i_section_length,
    input  logic        i_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_network_id,
    output logic [15:0] o_program_number,
    output logic        o_eit_schedule,
    output logic        o_eit_present_following,
    output logic [2:0]  o_running_state,
    output logic        o_scrambled,
    output logic [11:0] o_descriptor_bytes,
    output logic [9:0]  o_service_index,
    output logic        o_section_done
);

    logic        r_in_valid;
    logic [7:0]  r_data_byte;
    logic [12:0] r_section_length;
    logic        r_first_byte;
    logic        r_out_valid;
    t_rec        r_rec;

    logic        out_free, fire, hit;
    t_rec        rec;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    sdt_walk #(
        .MAX_SECTION_BYTES(MAX_SECTION_BYTES)
    ) u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_data_byte     (r_data_byte),
        .i_section_length(r_section_length),
        .i_first_byte    (r_first_byte),
        .o_hit           (hit),
        .o_rec           (rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_data_byte      <= i_data_byte;
            r_section_length <= i_section_length;
            r_first_byte     <= i_first_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && hit) begin
            r_rec <= rec;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_kind                  = r_rec.kind;
    assign o_network_id            = r_rec.network_id;
    assign o_program_number        = r_rec.program_number;
    assign o_eit_schedule          = r_rec.eit_schedule;
    assign o_eit_present_following = r_rec.eit_present_following;
    assign o_running_state         = r_rec.running_state;
    assign o_scrambled             = r_rec.scrambled;
    assign o_descriptor_bytes      = r_rec.descriptor_bytes;
    assign o_service_index         = r_rec.service_index;
    assign o_section_done          = r_rec.section_done;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_section_done == (o_kind != KIND_SERVICE)))
        else $error("section_done disagrees with record kind");

    a_closing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_SERVICE) |->
            (o_program_number == 16'd0 && o_descriptor_bytes == 12'd0))
        else $error("end or error record carries service fields");

endmodule
